// File: hw/rtl/length_framed_checksum_deframer_assert.svh
// Assertion macros used by the deframer parser.
`ifndef LENGTH_FRAMED_CHECKSUM_DEFRAMER_ASSERT_SVH
`define LENGTH_FRAMED_CHECKSUM_DEFRAMER_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define LFCD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("deframer assertion failed");

// Check that a condition never holds outside reset.
`define LFCD_ASSERT_NEVER(lbl, clk, rstn, cond) \
  `LFCD_ASSERT(lbl, clk, rstn, !(cond))

`endif

// File: hw/rtl/lfcd_pkg.sv
`timescale 1ns / 1ps

package lfcd_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned LenW        = 16;
  localparam int unsigned FrameLenW   = 17;
  localparam int unsigned HdrPosW     = 5;
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 17;

  localparam int unsigned LengthPosDefault = 27;

  localparam logic [ByteW-1:0]     StartByteRst   = 8'd123;
  localparam logic [ByteW-1:0]     EndByteRst     = 8'd125;
  localparam logic [FrameLenW-1:0] MaxFrameLenRst = 17'd1024;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_HEADER  = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_CHECK   = 3'd3,
    PH_END     = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_CHECKSUM = 2'd1,
    ERR_END_BYTE = 2'd2,
    ERR_TOO_LONG = 2'd3
  } err_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_BYTE    = 2'd0,
    CFG_END_BYTE      = 2'd1,
    CFG_MAX_FRAME_LEN = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0]     start_byte;
    logic [ByteW-1:0]     end_byte;
    logic [FrameLenW-1:0] max_frame_len;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] byte_out;
    logic             in_frame;
    logic             frame_ok;
    err_e             error_code;
    logic [LenW-1:0]  payload_length;
  } result_t;

endpackage

// File: hw/rtl/lfcd_cfg_regs.sv
`timescale 1ns / 1ps

module lfcd_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lfcd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lfcd_pkg::CfgDataW-1:0] cfg_data_i,
  output lfcd_pkg::cfg_t                cfg_o
);
  import lfcd_pkg::*;

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Writes to an unused index are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_byte    <= StartByteRst;
      cfg_q.end_byte      <= EndByteRst;
      cfg_q.max_frame_len <= MaxFrameLenRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_START_BYTE:    cfg_q.start_byte    <= cfg_data_i[ByteW-1:0];
        CFG_END_BYTE:      cfg_q.end_byte      <= cfg_data_i[ByteW-1:0];
        CFG_MAX_FRAME_LEN: cfg_q.max_frame_len <= cfg_data_i[FrameLenW-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: hw/rtl/lfcd_parser.sv
`timescale 1ns / 1ps

`include "length_framed_checksum_deframer_assert.svh"

module lfcd_parser #(
  parameter int unsigned LengthPos = lfcd_pkg::LengthPosDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       adv_i,
  input  logic [lfcd_pkg::ByteW-1:0] byte_i,
  input  lfcd_pkg::cfg_t             cfg_i,
  output lfcd_pkg::result_t          res_o
);
  import lfcd_pkg::*;

  localparam logic [HdrPosW-1:0]   LenHiPos = HdrPosW'(LengthPos);
  localparam logic [HdrPosW-1:0]   LenLoPos = HdrPosW'(LengthPos + 1);
  localparam logic [FrameLenW-1:0] Overhead = FrameLenW'(LengthPos + 4);

  phase_e             phase_q, phase_d;
  logic [HdrPosW-1:0] hdr_pos_q, hdr_pos_d;
  logic [ByteW-1:0]   len_hi_q, len_hi_d;
  logic [LenW-1:0]    data_len_q, data_len_d;
  logic [LenW-1:0]    remain_q, remain_d;
  logic [ByteW-1:0]   sum_q, sum_d;

  logic [HdrPosW-1:0]   pos;
  logic [LenW-1:0]      len_word;
  logic [FrameLenW-1:0] frame_len;
  logic                 taken;
  logic                 ok;
  err_e                 err;
  logic                 finish;

  assign pos       = hdr_pos_q + HdrPosW'(1);
  assign len_word  = {len_hi_q, byte_i};
  assign frame_len = {1'b0, len_word} + Overhead;

  always_comb begin
    phase_d    = phase_q;
    hdr_pos_d  = hdr_pos_q;
    len_hi_d   = len_hi_q;
    data_len_d = data_len_q;
    remain_d   = remain_q;
    sum_d      = sum_q;
    taken      = 1'b1;
    ok         = 1'b0;
    err        = ERR_NONE;
    finish     = 1'b0;

    unique case (phase_q)
      PH_HEADER: begin
        sum_d     = sum_q + byte_i;
        hdr_pos_d = pos;
        if (pos == LenHiPos) begin
          len_hi_d = byte_i;
        end else if (pos == LenLoPos) begin
          data_len_d = len_word;
          remain_d   = len_word;
          if (frame_len > cfg_i.max_frame_len) begin
            err    = ERR_TOO_LONG;
            finish = 1'b1;
          end else begin
            phase_d = (len_word != '0) ? PH_PAYLOAD : PH_CHECK;
          end
        end
      end
      PH_PAYLOAD: begin
        sum_d    = sum_q + byte_i;
        remain_d = remain_q - LenW'(1);
        if (remain_d == '0) begin
          phase_d = PH_CHECK;
        end
      end
      PH_CHECK: begin
        if (byte_i != sum_q) begin
          err    = ERR_CHECKSUM;
          finish = 1'b1;
        end else begin
          phase_d = PH_END;
        end
      end
      PH_END: begin
        if (byte_i != cfg_i.end_byte) begin
          err = ERR_END_BYTE;
        end else begin
          ok = 1'b1;
        end
        finish = 1'b1;
      end
      default: begin
        // Hunt; unused phase codes land here too.
        if (byte_i == cfg_i.start_byte) begin
          phase_d    = PH_HEADER;
          hdr_pos_d  = '0;
          len_hi_d   = '0;
          data_len_d = '0;
          remain_d   = '0;
          sum_d      = '0;
        end else begin
          taken = 1'b0;
        end
      end
    endcase

    res_o.byte_out       = byte_i;
    res_o.in_frame       = taken;
    res_o.frame_ok       = ok;
    res_o.error_code     = err;
    res_o.payload_length = data_len_d;

    // Drop all frame state once the frame ends, good or bad.
    if (finish) begin
      phase_d    = PH_HUNT;
      hdr_pos_d  = '0;
      len_hi_d   = '0;
      data_len_d = '0;
      remain_d   = '0;
      sum_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      hdr_pos_q  <= '0;
      len_hi_q   <= '0;
      data_len_q <= '0;
      remain_q   <= '0;
      sum_q      <= '0;
    end else if (adv_i) begin
      phase_q    <= phase_d;
      hdr_pos_q  <= hdr_pos_d;
      len_hi_q   <= len_hi_d;
      data_len_q <= data_len_d;
      remain_q   <= remain_d;
      sum_q      <= sum_d;
    end
  end

  `LFCD_ASSERT(a_ok_no_err, clk_i, rst_ni, res_o.frame_ok |-> res_o.error_code == ERR_NONE)
  `LFCD_ASSERT(a_end_to_hunt, clk_i, rst_ni,
               adv_i && (res_o.frame_ok || res_o.error_code != ERR_NONE) |=> phase_q == PH_HUNT)
  `LFCD_ASSERT(a_last_payload, clk_i, rst_ni,
               adv_i && phase_q == PH_PAYLOAD && remain_q == LenW'(1) |=> phase_q == PH_CHECK)
  `LFCD_ASSERT_NEVER(a_hunt_clean, clk_i, rst_ni,
                     phase_q == PH_HUNT && (data_len_q != '0 || sum_q != '0))
  `LFCD_ASSERT_NEVER(a_err_outside, clk_i, rst_ni,
                     !res_o.in_frame && (res_o.frame_ok || res_o.error_code != ERR_NONE))

endmodule

// File: hw/rtl/length_framed_checksum_deframer.sv
`timescale 1ns / 1ps
// A byte is taken into the input register; its result word is registered into the output register once that is free.
// Throughput: one byte per cycle while the output does not stall; the running sum and counters update combinationally.
// An input register and an output register part the two sides, so one byte can
// still be taken into an empty input register while a finished result waits on a stalled output.
// Reset (rst_ni low, asynchronous): hunting, counters and sum cleared,
// registers back to start 123, end 125, maximum frame length 1024.

module length_framed_checksum_deframer #(
  parameter int unsigned LengthPos = lfcd_pkg::LengthPosDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [lfcd_pkg::ByteW-1:0]    byte_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lfcd_pkg::ByteW-1:0]    byte_out_o,
  output logic                          in_frame_o,
  output logic                          frame_ok_o,
  output logic [1:0]                    error_code_o,
  output logic [lfcd_pkg::LenW-1:0]     payload_length_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lfcd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lfcd_pkg::CfgDataW-1:0] cfg_data_i
);
  import lfcd_pkg::*;

  cfg_t             cfg;
  result_t          res;
  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_valid_q;
  result_t          out_q;
  logic             out_free;
  logic             adv;
  logic             in_take;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  lfcd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lfcd_parser #(
    .LengthPos (LengthPos)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .byte_i (in_byte_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q <= byte_in_i;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign byte_out_o       = out_q.byte_out;
  assign in_frame_o       = out_q.in_frame;
  assign frame_ok_o       = out_q.frame_ok;
  assign error_code_o     = out_q.error_code;
  assign payload_length_o = out_q.payload_length;

endmodule
